FILE: design/pnrm_pkg.sv
package pnrm_pkg;
   localparam int PEERS_DEFAULT = 8;
   localparam int MSG_BITS_DEFAULT = 32;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_TX = 2'd1;
   localparam logic [1:0] MODE_RX = 2'd2;
   localparam logic [1:0] MODE_TICK = 2'd3;

   localparam logic [3:0] ST_OK = 4'd0;
   localparam logic [3:0] ST_CRYPTO = 4'd1;
   localparam logic [3:0] ST_NOSPACE = 4'd2;
   localparam logic [3:0] ST_KEYREQ = 4'd3;
   localparam logic [3:0] ST_UNKNOWN = 4'd4;
   localparam logic [3:0] ST_REPLAY = 4'd5;
   localparam logic [3:0] ST_UPDATE = 4'd6;
   localparam logic [3:0] ST_EXPIRED = 4'd7;
   localparam logic [3:0] ST_IDLE = 4'd8;
   localparam logic [3:0] ST_LOADED = 4'd9;

   localparam logic [1:0] FR_FRESH = 2'd0;
   localparam logic [1:0] FR_EXPIRED = 2'd1;
   localparam logic [1:0] FR_UPDATE = 2'd2;

   localparam logic CSR_MAX_MSG = 1'b0;
   localparam logic CSR_MAX_NONCE = 1'b1;

   localparam logic [7:0] NONCE_TOP = 8'hff;

   typedef struct packed {
      logic [1:0]  mode;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [31:0] msg_counter;
      logic [7:0]  nonce_counter;
      logic        crypto_ok;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [2:0]  slot;
      logic [31:0] out_msg_counter;
      logic [7:0]  out_nonce_counter;
   } rsp_type;
endpackage

FILE: design/pnrm_if.sv
interface pnrm_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

FILE: design/peer_nonce_replay_manager.sv
// Peer nonce and replay manager.
// req_ channel: one transaction per request (load, transmit, receive, tick).
// rsp_ channel: exactly one result transaction per request, in order.
// csr_ port: write the message limit (index 0) and the nonce limit (index 1)
// only while idle.
// A two-entry request queue feeds the table engine. The engine matches the
// address over the peer table in the cycle it takes a request and does the
// read-modify-write of the matched entry in the next cycle, which loads the
// output register. It takes the next request only after its result has left
// the output register.
// Reset (synchronous) empties the table and queue and restores the limits.
// A stalled rsp_ready holds the result; the queue keeps taking requests until
// it is full.
module peer_nonce_replay_manager
   import pnrm_pkg::*;
#(
   parameter int PEERS = PEERS_DEFAULT,
   parameter int MSG_COUNTER_BITS = MSG_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   pnrm_if.sink        req,
   pnrm_if.source      rsp,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   logic [31:0] max_msg_ff;
   logic [7:0] max_nonce_ff;
   logic q_valid, q_ready;
   req_type q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_msg_ff <= 32'd65535;
         max_nonce_ff <= 8'd255;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MAX_MSG: max_msg_ff <= csr_data;
            CSR_MAX_NONCE: max_nonce_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   pnrm_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.payload),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
   );

   pnrm_back #(.PEERS(PEERS), .MSG_COUNTER_BITS(MSG_COUNTER_BITS)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
      .max_msg(max_msg_ff), .max_nonce(max_nonce_ff),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.payload)
   );
endmodule

FILE: design/pnrm_front.sv
module pnrm_front
   import pnrm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    q_valid,
   input  logic    q_ready,
   output req_type q_data
);
   // two-entry queue; msg_counter masked to the configured width by the back end
   req_type ent_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, rd_in;
   logic wr_ff, wr_in;
   logic push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_data = ent_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in = rd_ff ^ pop;
      wr_in = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
      if (push) ent_ff[wr_ff] <= in_data;
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue overflow");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) |-> (rd_ff != wr_ff)) else $error("queue pointers");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (cnt_ff == $past(cnt_ff) - 2'd1)) else $error("pop count");
endmodule

FILE: design/pnrm_back.sv
module pnrm_back
   import pnrm_pkg::*;
#(
   parameter int PEERS = PEERS_DEFAULT,
   parameter int MSG_COUNTER_BITS = MSG_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_ready,
   input  req_type     q_data,
   input  logic [31:0] max_msg,
   input  logic [7:0]  max_nonce,
   output logic        out_valid,
   input  logic        out_ready,
   output rsp_type     out_data
);
   localparam int SW = (PEERS > 1) ? $clog2(PEERS) : 1;
   localparam int CW = $clog2(PEERS + 1);
   localparam logic [31:0] MSG_MASK = 32'((64'd1 << MSG_COUNTER_BITS) - 64'd1);

   logic [63:0] ahi_ff [PEERS];
   logic [63:0] alo_ff [PEERS];
   logic [MSG_COUNTER_BITS-1:0] txm_ff [PEERS];
   logic [7:0] txn_ff [PEERS];
   logic [MSG_COUNTER_BITS-1:0] rxm_ff [PEERS];
   logic [7:0] rxn_ff [PEERS];
   logic [1:0] fr_ff [PEERS];
   logic [CW-1:0] known_ff;

   // stage 1: match, stage 2: update
   logic ph_ff;
   req_type r_ff;
   logic hit_ff, upd_hit_ff, exp_hit_ff;
   logic [SW-1:0] hs_ff, us_ff, es_ff;
   logic res_valid_ff;
   rsp_type res_ff;

   function automatic rsp_type mk_rsp(logic [3:0] st, logic [2:0] sl, logic [31:0] m,
                                      logic [7:0] n);
      rsp_type r;
      r.status = st;
      r.slot = sl;
      r.out_msg_counter = m;
      r.out_nonce_counter = n;
      return r;
   endfunction

   logic hit, uh, eh;
   logic [SW-1:0] hs, us, es;
   always_comb begin
      hit = 1'b0; uh = 1'b0; eh = 1'b0;
      hs = '0; us = '0; es = '0;
      for (int i = PEERS - 1; i >= 0; i--) begin
         if (CW'(i) < known_ff) begin
            if (ahi_ff[i] == q_data.addr_high && alo_ff[i] == q_data.addr_low) begin
               hit = 1'b1; hs = SW'(i);
            end
            if (fr_ff[i] == FR_UPDATE) begin
               uh = 1'b1; us = SW'(i);
            end
            if (fr_ff[i] == FR_EXPIRED) begin
               eh = 1'b1; es = SW'(i);
            end
         end
      end
   end

   assign q_ready = !ph_ff && !res_valid_ff;
   assign out_valid = res_valid_ff;
   assign out_data = res_ff;

   logic full;
   logic [SW-1:0] ns;
   logic [MSG_COUNTER_BITS-1:0] rm, tm;
   logic [7:0] tn;
   assign full = (known_ff >= CW'(PEERS));
   assign ns = SW'(known_ff);
   assign rm = MSG_COUNTER_BITS'(r_ff.msg_counter & MSG_MASK);
   assign tm = txm_ff[hs_ff];
   assign tn = txn_ff[hs_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= 1'b0;
         res_valid_ff <= 1'b0;
         known_ff <= '0;
         for (int i = 0; i < PEERS; i++) begin
            ahi_ff[i] <= '0; alo_ff[i] <= '0; txm_ff[i] <= '0; txn_ff[i] <= '0;
            rxm_ff[i] <= '0; rxn_ff[i] <= '0; fr_ff[i] <= FR_FRESH;
         end
      end else begin
         if (res_valid_ff && out_ready) res_valid_ff <= 1'b0;
         if (q_valid && q_ready) begin
            ph_ff <= 1'b1;
            r_ff <= q_data;
            hit_ff <= hit; hs_ff <= hs;
            upd_hit_ff <= uh; us_ff <= us;
            exp_hit_ff <= eh; es_ff <= es;
         end
         if (ph_ff) begin
            ph_ff <= 1'b0;
            res_valid_ff <= 1'b1;
            unique case (r_ff.mode)
               MODE_LOAD: begin
                  if (r_ff.nonce_counter == 8'd0) begin
                     res_ff <= mk_rsp(ST_IDLE, '0, '0, '0);
                  end else if (full) begin
                     res_ff <= mk_rsp(ST_NOSPACE, '0, '0, '0);
                  end else begin
                     ahi_ff[ns] <= r_ff.addr_high; alo_ff[ns] <= r_ff.addr_low;
                     txm_ff[ns] <= '0; rxm_ff[ns] <= '0; rxn_ff[ns] <= '0;
                     known_ff <= known_ff + 1'b1;
                     if (r_ff.nonce_counter == NONCE_TOP) begin
                        fr_ff[ns] <= FR_EXPIRED; txn_ff[ns] <= NONCE_TOP;
                        res_ff <= mk_rsp(ST_LOADED, 3'(ns), '0, NONCE_TOP);
                     end else begin
                        fr_ff[ns] <= FR_FRESH;
                        txn_ff[ns] <= r_ff.nonce_counter + 8'd1;
                        res_ff <= mk_rsp(ST_LOADED, 3'(ns), '0, r_ff.nonce_counter + 8'd1);
                     end
                  end
               end
               MODE_TX: begin
                  if (r_ff.addr_high == '0 && r_ff.addr_low == '0) begin
                     res_ff <= mk_rsp(ST_CRYPTO, '0, '0, '0);
                  end else if (!hit_ff) begin
                     if (full) res_ff <= mk_rsp(ST_NOSPACE, '0, '0, '0);
                     else begin
                        ahi_ff[ns] <= r_ff.addr_high; alo_ff[ns] <= r_ff.addr_low;
                        txm_ff[ns] <= '0; txn_ff[ns] <= '0;
                        rxm_ff[ns] <= '0; rxn_ff[ns] <= '0;
                        fr_ff[ns] <= FR_EXPIRED;
                        known_ff <= known_ff + 1'b1;
                        res_ff <= mk_rsp(ST_KEYREQ, 3'(ns), '0, '0);
                     end
                  end else begin
                     if (fr_ff[hs_ff] != FR_FRESH) begin
                        res_ff <= mk_rsp(ST_KEYREQ, 3'(hs_ff), '0, '0);
                     end else if (tn == max_nonce) begin
                        fr_ff[hs_ff] <= FR_EXPIRED;
                        res_ff <= mk_rsp(ST_KEYREQ, 3'(hs_ff), '0, '0);
                     end else if (32'(tm) == max_msg) begin
                        txn_ff[hs_ff] <= tn + 8'd1;
                        txm_ff[hs_ff] <= MSG_COUNTER_BITS'(1);
                        fr_ff[hs_ff] <= FR_UPDATE;
                        res_ff <= mk_rsp(ST_OK, 3'(hs_ff), '0, tn + 8'd1);
                     end else begin
                        txm_ff[hs_ff] <= tm + 1'b1;
                        res_ff <= mk_rsp(ST_OK, 3'(hs_ff), 32'(tm), tn);
                     end
                  end
               end
               MODE_RX: begin
                  if (!hit_ff) res_ff <= mk_rsp(ST_UNKNOWN, '0, '0, '0);
                  else begin
                     if (fr_ff[hs_ff] == FR_EXPIRED) begin
                        res_ff <= mk_rsp(ST_KEYREQ, 3'(hs_ff), '0, '0);
                     end else if (rm <= rxm_ff[hs_ff] || r_ff.nonce_counter < rxn_ff[hs_ff]) begin
                        res_ff <= mk_rsp(ST_REPLAY, 3'(hs_ff), '0, '0);
                     end else if (!r_ff.crypto_ok) begin
                        res_ff <= mk_rsp(ST_CRYPTO, 3'(hs_ff), '0, '0);
                     end else begin
                        rxm_ff[hs_ff] <= rm; rxn_ff[hs_ff] <= r_ff.nonce_counter;
                        res_ff <= mk_rsp(ST_OK, 3'(hs_ff), '0, '0);
                     end
                  end
               end
               MODE_TICK: begin
                  if (upd_hit_ff) begin
                     fr_ff[us_ff] <= FR_FRESH;
                     res_ff <= mk_rsp(ST_UPDATE, 3'(us_ff), '0, txn_ff[us_ff]);
                  end else if (exp_hit_ff) begin
                     res_ff <= mk_rsp(ST_EXPIRED, 3'(es_ff), '0, '0);
                  end else begin
                     res_ff <= mk_rsp(ST_IDLE, '0, '0, '0);
                  end
               end
               default: ;
            endcase
         end
      end
   end

   a_known: assert property (@(posedge clock) disable iff (reset) known_ff <= CW'(PEERS))
      else $error("table count");
   a_one: assert property (@(posedge clock) disable iff (reset) !(ph_ff && res_valid_ff))
      else $error("overlap");
   a_res: assert property (@(posedge clock) disable iff (reset) ph_ff |=> res_valid_ff)
      else $error("no result");
endmodule

FILE: sim/pnrm_checker.sv
module pnrm_checker
   import pnrm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_payload,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [31:0] csr_data,
   output int          errors,
   output int          pending,
   output int          results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPEERS = PEERS_DEFAULT;

   logic [63:0] tbl_hi [NPEERS];
   logic [63:0] tbl_lo [NPEERS];
   logic [31:0] tbl_txm [NPEERS];
   logic [7:0]  tbl_txn [NPEERS];
   logic [31:0] tbl_rxm [NPEERS];
   logic [7:0]  tbl_rxn [NPEERS];
   logic [1:0]  tbl_fr [NPEERS];
   int          peers_known;
   logic [31:0] lim_msg;
   logic [7:0]  lim_nonce;
   rsp_type     expected_rsp [$];

   function automatic rsp_type mk(logic [3:0] st, int sl, logic [31:0] m, logic [7:0] n);
      rsp_type r;
      r.status = st;
      r.slot = sl[2:0];
      r.out_msg_counter = m;
      r.out_nonce_counter = n;
      return r;
   endfunction

   function automatic int find_peer(logic [63:0] hi, logic [63:0] lo);
      for (int i = 0; i < peers_known; i++)
         if (tbl_hi[i] == hi && tbl_lo[i] == lo) return i;
      return -1;
   endfunction

   function automatic int add_peer(logic [63:0] hi, logic [63:0] lo);
      int s;
      s = peers_known;
      if (s >= NPEERS) return -1;
      tbl_hi[s] = hi;
      tbl_lo[s] = lo;
      tbl_txm[s] = '0;
      tbl_txn[s] = '0;
      tbl_rxm[s] = '0;
      tbl_rxn[s] = '0;
      tbl_fr[s] = FR_FRESH;
      peers_known = s + 1;
      return s;
   endfunction

   function automatic int find_code(logic [1:0] code);
      for (int i = 0; i < peers_known; i++)
         if (tbl_fr[i] == code) return i;
      return -1;
   endfunction

   function automatic rsp_type predict_nonce_rsp(req_type q);
      int s;
      logic [31:0] m;
      case (q.mode)
         MODE_LOAD: begin
            if (q.nonce_counter == 8'd0) return mk(ST_IDLE, 0, '0, '0);
            s = add_peer(q.addr_high, q.addr_low);
            if (s < 0) return mk(ST_NOSPACE, 0, '0, '0);
            if (q.nonce_counter == NONCE_TOP) begin
               tbl_fr[s] = FR_EXPIRED;
               tbl_txn[s] = q.nonce_counter;
            end else begin
               tbl_fr[s] = FR_FRESH;
               tbl_txn[s] = q.nonce_counter + 8'd1;
            end
            return mk(ST_LOADED, s, '0, tbl_txn[s]);
         end
         MODE_TX: begin
            if (q.addr_high == '0 && q.addr_low == '0) return mk(ST_CRYPTO, 0, '0, '0);
            s = find_peer(q.addr_high, q.addr_low);
            if (s < 0) begin
               s = add_peer(q.addr_high, q.addr_low);
               if (s < 0) return mk(ST_NOSPACE, 0, '0, '0);
               tbl_fr[s] = FR_EXPIRED;
               return mk(ST_KEYREQ, s, '0, '0);
            end
            if (tbl_fr[s] != FR_FRESH) return mk(ST_KEYREQ, s, '0, '0);
            if (tbl_txn[s] == lim_nonce) begin
               tbl_fr[s] = FR_EXPIRED;
               return mk(ST_KEYREQ, s, '0, '0);
            end
            if (tbl_txm[s] == lim_msg) begin
               tbl_txn[s] = tbl_txn[s] + 8'd1;
               tbl_txm[s] = '0;
               tbl_fr[s] = FR_UPDATE;
            end
            m = tbl_txm[s];
            tbl_txm[s] = m + 32'd1;
            return mk(ST_OK, s, m, tbl_txn[s]);
         end
         MODE_RX: begin
            s = find_peer(q.addr_high, q.addr_low);
            if (s < 0) return mk(ST_UNKNOWN, 0, '0, '0);
            if (tbl_fr[s] == FR_EXPIRED) return mk(ST_KEYREQ, s, '0, '0);
            if (q.msg_counter <= tbl_rxm[s] || q.nonce_counter < tbl_rxn[s])
               return mk(ST_REPLAY, s, '0, '0);
            if (!q.crypto_ok) return mk(ST_CRYPTO, s, '0, '0);
            tbl_rxm[s] = q.msg_counter;
            tbl_rxn[s] = q.nonce_counter;
            return mk(ST_OK, s, '0, '0);
         end
         default: begin
            s = find_code(FR_UPDATE);
            if (s >= 0) begin
               tbl_fr[s] = FR_FRESH;
               return mk(ST_UPDATE, s, '0, tbl_txn[s]);
            end
            s = find_code(FR_EXPIRED);
            if (s >= 0) return mk(ST_EXPIRED, s, '0, '0);
            return mk(ST_IDLE, 0, '0, '0);
         end
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < NPEERS; i++) begin
            tbl_hi[i] = '0; tbl_lo[i] = '0; tbl_txm[i] = '0; tbl_txn[i] = '0;
            tbl_rxm[i] = '0; tbl_rxn[i] = '0; tbl_fr[i] = FR_FRESH;
         end
         peers_known = 0;
         lim_msg = 32'd65535;
         lim_nonce = 8'd255;
         expected_rsp.delete();
         errors = 0;
         results_seen = 0;
         pending = 0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_MAX_MSG) lim_msg = csr_data;
            else lim_nonce = csr_data[7:0];
         end
         if (req_valid && req_ready)
            expected_rsp.push_back(predict_nonce_rsp(req_payload));
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_rsp.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected transaction %p", rsp_payload);
            end else begin
               want = expected_rsp.pop_front();
               if (want.status !== rsp_payload.status || want.slot !== rsp_payload.slot
                   || want.out_msg_counter !== rsp_payload.out_msg_counter
                   || want.out_nonce_counter !== rsp_payload.out_nonce_counter) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp st=%0d slot=%0d m=%h n=%h got st=%0d slot=%0d m=%h n=%h",
                        want.status, want.slot, want.out_msg_counter, want.out_nonce_counter,
                        rsp_payload.status, rsp_payload.slot, rsp_payload.out_msg_counter,
                        rsp_payload.out_nonce_counter);
               end
            end
         end
         pending = expected_rsp.size();
      end
   end
endmodule

FILE: sim/tb_top.sv
module tb_top
   import pnrm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write = 0;
   logic        csr_index = 0;
   logic [31:0] csr_data = '0;
   int          errors, pending, results_seen;
   int          cycles = 0;
   int          sent = 0;
   logic [63:0] pool_hi [6];
   logic [63:0] pool_lo [6];

   pnrm_if #(.payload_type(req_type)) req_ch();
   pnrm_if #(.payload_type(rsp_type)) rsp_ch();

   peer_nonce_replay_manager dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data));

   pnrm_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_payload(req_ch.payload),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_payload(rsp_ch.payload),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .errors(errors), .pending(pending), .results_seen(results_seen));

   initial begin
      req_ch.valid = 0;
      req_ch.payload = '0;
      rsp_ch.ready = 0;
   end

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_top: done, errors");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 0;
      else if (cycles % 3000 < 600) rsp_ch.ready <= 1;
      else rsp_ch.ready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
   end

   task automatic send(logic [1:0] md, logic [63:0] hi, logic [63:0] lo,
                       logic [31:0] mc, logic [7:0] nc, logic ok);
      req_type q;
      int g;
      g = (cycles % 3000 < 600) ? 0 : gap_len();
      if (g > 0) begin
         req_ch.valid <= 0;
         repeat (g) @(posedge clock);
      end
      q.mode = md; q.addr_high = hi; q.addr_low = lo;
      q.msg_counter = mc; q.nonce_counter = nc; q.crypto_ok = ok;
      req_ch.valid <= 1;
      req_ch.payload <= q;
      do @(posedge clock); while (!req_ch.ready);
      sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      do @(posedge clock); while (pending != 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [31:0] val);
      csr_write <= 1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      csr_write <= 0;
      @(posedge clock);
   endtask

   task automatic random_phase(int n);
      int p, k;
      logic [1:0] md;
      for (int i = 0; i < n; i++) begin
         p = $urandom_range(0, 5);
         k = $urandom_range(0, 99);
         if (k < 8) md = MODE_LOAD;
         else if (k < 55) md = MODE_TX;
         else if (k < 85) md = MODE_RX;
         else md = MODE_TICK;
         if (k % 17 == 0)
            send(md, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         else
            send(md, pool_hi[p], pool_lo[p],
                 ($urandom_range(0, 3) == 0) ? $urandom : 32'(i * 5 + $urandom_range(0, 9)),
                 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, 3)),
                 $urandom_range(0, 7) != 0);
      end
   endtask

   task automatic reset_table();
      // no in-band clear: table persists, so vary pools instead
      for (int i = 0; i < 6; i++) begin
         pool_hi[i] = {$urandom, $urandom};
         pool_lo[i] = (i == 5) ? 64'h0 : {$urandom, $urandom};
      end
      pool_hi[5] = '0;
   endtask

   initial begin
      reset_table();
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send(MODE_TICK, '0, '0, '0, '0, 1'b0);
      send(MODE_LOAD, 64'h1, 64'h2, '0, 8'd0, 1'b0);
      send(MODE_LOAD, 64'h1, 64'h2, '0, 8'd5, 1'b0);
      send(MODE_LOAD, '1, '1, '1, 8'hff, 1'b1);
      send(MODE_LOAD, 64'h1, 64'h2, '0, 8'hfe, 1'b0);
      send(MODE_TX, '0, '0, '0, '0, 1'b0);
      send(MODE_TX, 64'h1, 64'h2, '0, '0, 1'b0);
      send(MODE_TX, '1, '1, '0, '0, 1'b0);
      send(MODE_TX, 64'h77, 64'h88, '0, '0, 1'b0);
      send(MODE_RX, 64'h9, 64'h9, 32'd5, 8'd5, 1'b1);
      send(MODE_RX, '1, '1, 32'd5, 8'd5, 1'b1);
      send(MODE_RX, 64'h1, 64'h2, 32'd10, 8'd3, 1'b0);
      send(MODE_RX, 64'h1, 64'h2, 32'd10, 8'd3, 1'b1);
      send(MODE_RX, 64'h1, 64'h2, 32'd10, 8'd4, 1'b1);
      send(MODE_RX, 64'h1, 64'h2, '1, 8'd2, 1'b1);
      send(MODE_RX, 64'h1, 64'h2, '1, 8'hff, 1'b1);
      send(MODE_TICK, '0, '0, '0, '0, 1'b0);
      drain();
      write_reg(CSR_MAX_MSG, 32'd1);
      write_reg(CSR_MAX_NONCE, 32'd9);
      send(MODE_TX, 64'h1, 64'h2, '0, '0, 1'b0);
      send(MODE_TX, 64'h1, 64'h2, '0, '0, 1'b0);
      send(MODE_TICK, '0, '0, '0, '0, 1'b0);
      send(MODE_TX, 64'h1, 64'h2, '0, '0, 1'b0);
      send(MODE_TX, 64'h1, 64'h2, '0, '0, 1'b0);
      send(MODE_LOAD, 64'h5, 64'h5, '0, 8'd1, 1'b0);
      send(MODE_LOAD, 64'h6, 64'h6, '0, 8'd1, 1'b0);
      send(MODE_LOAD, 64'h7, 64'h7, '0, 8'd1, 1'b0);
      send(MODE_LOAD, 64'h8, 64'h8, '0, 8'd1, 1'b0);
      send(MODE_TX, 64'h3, 64'h3, '0, '0, 1'b0);
      drain();
      // table now full; the rest exercises lookups against these peers
      for (int i = 0; i < 5; i++) begin
         pool_hi[i] = (i < 4) ? 64'h5 + i : 64'h1;
         pool_lo[i] = (i < 4) ? 64'h5 + i : 64'h2;
      end
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin write_reg(CSR_MAX_MSG, 32'd0); write_reg(CSR_MAX_NONCE, 32'd1); end
            1: begin write_reg(CSR_MAX_MSG, 32'd3); write_reg(CSR_MAX_NONCE, 32'd255); end
            2: begin write_reg(CSR_MAX_MSG, '1); write_reg(CSR_MAX_NONCE, 32'd40); end
            3: begin write_reg(CSR_MAX_MSG, $urandom_range(2, 20));
                     write_reg(CSR_MAX_NONCE, $urandom_range(1, 255)); end
            4: begin write_reg(CSR_MAX_MSG, 32'd7); write_reg(CSR_MAX_NONCE, 32'd200); end
            default: begin
               write_reg(CSR_MAX_MSG, 32'd65535); write_reg(CSR_MAX_NONCE, 32'd255);
            end
         endcase
         random_phase(280);
         drain();
      end
      $display("covered %0d requests, %0d results, six limit settings, full table", sent,
         results_seen);
      if (errors == 0) $display("tb_top: done, clean");
      else $display("tb_top: done, errors");
      $finish;
   end
endmodule

FILE: files.f
design/pnrm_pkg.sv
design/pnrm_if.sv
design/pnrm_front.sv
design/pnrm_back.sv
design/peer_nonce_replay_manager.sv
sim/pnrm_checker.sv
sim/tb_top.sv
